@@ design/sxt_pkg.sv @@
// ----------------------------------------------------------------------------
// sxt_pkg
// Shared types and constants of the S-expression tokenizer: token kinds,
// result words, per-byte result bundles and the position counter width.
// ----------------------------------------------------------------------------
package sxt_pkg;

	// row, column and length counters
	localparam int POS_BITS = 16;
	localparam int OUT_BITS = 16;
	localparam int CLAMP_BITS = (POS_BITS > OUT_BITS) ? POS_BITS : OUT_BITS;

	// results one byte can cause, and bundles the queue holds
	localparam int MAX_RES = 3;
	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	typedef logic [POS_BITS-1:0] pos_t;

	typedef enum logic [2:0] {
		KIND_LPAR  = 3'd0,
		KIND_RPAR  = 3'd1,
		KIND_STR   = 3'd2,
		KIND_INT   = 3'd3,
		KIND_ID    = 3'd4,
		KIND_DEF   = 3'd5,
		KIND_ERR   = 3'd6,
		KIND_DONE  = 3'd7
	} kind_t;

	// one result word as it leaves the block
	typedef struct packed {
		kind_t       kind;
		logic [15:0] row;
		logic [15:0] col;
		logic [15:0] len;
		logic [7:0]  bad;
		logic        last;
	} result_t;

	// all results caused by one input word, count from 1 to MAX_RES
	typedef struct packed {
		logic [1:0]           cnt;
		result_t [MAX_RES-1:0] res;
	} bundle_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// saturating position to output width
	function automatic logic [OUT_BITS-1:0] clamp_pos(input pos_t v);
		logic [CLAMP_BITS-1:0] w;
		w = CLAMP_BITS'(v);
		if (w > CLAMP_BITS'({OUT_BITS{1'b1}}))
			return {OUT_BITS{1'b1}};
		else
			return w[OUT_BITS-1:0];
	endfunction

	// saturating increment
	function automatic pos_t sat_inc(input pos_t v);
		if (v == {POS_BITS{1'b1}})
			return v;
		else
			return v + pos_t'(1);
	endfunction

endpackage

@@ design/sxt_front.sv @@
// ----------------------------------------------------------------------------
// sxt_front
// Scanner: takes one source byte a cycle while the queue is not full, keeps
// the lexer state and forms the bundle of results that byte causes.
// ----------------------------------------------------------------------------
module sxt_front import sxt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic [7:0] char_code,
	input  logic    char_valid,
	input  logic    end_of_text,
	input  q_stat_t q_stat,
	output logic    push,
	output bundle_t push_data
);

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_STR     = 5'b00010,
		MODE_INT     = 5'b00100,
		MODE_ID      = 5'b01000,
		MODE_DISCARD = 5'b10000
	} mode_t;

	localparam logic [2:0] KW_START = 3'd0;
	localparam logic [2:0] KW_D     = 3'd1;
	localparam logic [2:0] KW_DE    = 3'd2;
	localparam logic [2:0] KW_DEF   = 3'd3;
	localparam logic [2:0] KW_MISS  = 3'd7;

	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_NL    = 8'h0A;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic [2:0] kw_next(input logic [2:0] kw, input logic [7:0] c);
		if (kw == KW_START && c == 8'h64)
			return KW_D;
		else if (kw == KW_D && c == 8'h65)
			return KW_DE;
		else if (kw == KW_DE && c == 8'h66)
			return KW_DEF;
		else
			return KW_MISS;
	endfunction

	function automatic result_t mk_res(input kind_t k, input pos_t r, input pos_t c,
			input pos_t l, input logic [7:0] b);
		result_t x;
		x.kind = k;
		x.row  = clamp_pos(r);
		x.col  = clamp_pos(c);
		x.len  = clamp_pos(l);
		x.bad  = b;
		x.last = 1'b0;
		return x;
	endfunction

	mode_t      mode_q, mode_d;
	pos_t       row_q, row_d;
	pos_t       col_q, col_d;
	pos_t       trow_q, trow_d;
	pos_t       tcol_q, tcol_d;
	pos_t       tlen_q, tlen_d;
	logic [2:0] kw_q, kw_d;
	logic [1:0] n_d;
	result_t [MAX_RES-1:0] res_d;
	kind_t      open_kind;
	logic       accept;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// kind of an open number or identifier when it closes
	assign open_kind = (mode_q == MODE_ID) ? ((kw_q == KW_DEF) ? KIND_DEF : KIND_ID)
		: KIND_INT;

	// next lexer state and the results of this byte
	always_comb begin
		mode_d = mode_q;
		row_d  = row_q;
		col_d  = col_q;
		trow_d = trow_q;
		tcol_d = tcol_q;
		tlen_d = tlen_q;
		kw_d   = kw_q;
		n_d    = 2'd0;
		res_d  = '0;
		if (mode_q == MODE_DISCARD) begin
			if (end_of_text) begin
				mode_d = MODE_IDLE;
				row_d  = '0;
				col_d  = '0;
				trow_d = '0;
				tcol_d = '0;
				tlen_d = '0;
				kw_d   = KW_START;
			end
		end else begin
			if (char_valid) begin
				if (mode_d == MODE_STR) begin
					col_d = sat_inc(col_d);
					if (char_code == CH_QUOTE) begin
						res_d[n_d] = mk_res(KIND_STR, trow_d, tcol_d, tlen_d, 8'h00);
						n_d = n_d + 2'd1;
						mode_d = MODE_IDLE;
					end else begin
						tlen_d = sat_inc(tlen_d);
					end
				end else if (mode_d == MODE_INT && is_digit(char_code)) begin
					tlen_d = sat_inc(tlen_d);
					col_d  = sat_inc(col_d);
				end else if (mode_d == MODE_ID && is_alpha(char_code)) begin
					tlen_d = sat_inc(tlen_d);
					kw_d   = kw_next(kw_d, char_code);
					col_d  = sat_inc(col_d);
				end else begin
					// close an open number or identifier first
					if (mode_d == MODE_INT || mode_d == MODE_ID) begin
						res_d[n_d] = mk_res(open_kind, trow_d, tcol_d, tlen_d, 8'h00);
						n_d = n_d + 2'd1;
						mode_d = MODE_IDLE;
					end
					// byte handled from idle
					if (char_code == CH_LPAR || char_code == CH_RPAR) begin
						res_d[n_d] = mk_res((char_code == CH_LPAR) ? KIND_LPAR : KIND_RPAR,
							row_d, col_d, pos_t'(1), 8'h00);
						n_d = n_d + 2'd1;
						col_d = sat_inc(col_d);
					end else if (char_code == CH_QUOTE) begin
						mode_d = MODE_STR;
						trow_d = row_d;
						tcol_d = col_d;
						tlen_d = '0;
						col_d  = sat_inc(col_d);
					end else if (char_code == CH_NL) begin
						row_d = sat_inc(row_d);
						col_d = '0;
					end else if (is_space(char_code)) begin
						col_d = sat_inc(col_d);
					end else if (is_digit(char_code)) begin
						mode_d = MODE_INT;
						trow_d = row_d;
						tcol_d = col_d;
						tlen_d = pos_t'(1);
						col_d  = sat_inc(col_d);
					end else if (is_alpha(char_code)) begin
						mode_d = MODE_ID;
						trow_d = row_d;
						tcol_d = col_d;
						tlen_d = pos_t'(1);
						kw_d   = kw_next(KW_START, char_code);
						col_d  = sat_inc(col_d);
					end else begin
						res_d[n_d] = mk_res(KIND_ERR, row_d, col_d, '0, char_code);
						n_d = n_d + 2'd1;
						mode_d = MODE_DISCARD;
					end
				end
			end
			// end of text: flush, then done or unterminated string error; nothing more after an error on this byte
			if (end_of_text) begin
				if (mode_d != MODE_DISCARD) begin
					if (mode_d == MODE_INT || mode_d == MODE_ID) begin
						res_d[n_d] = mk_res((mode_d == MODE_ID)
							? ((kw_d == KW_DEF) ? KIND_DEF : KIND_ID) : KIND_INT,
							trow_d, tcol_d, tlen_d, 8'h00);
						n_d = n_d + 2'd1;
					end
					if (mode_d == MODE_STR)
						res_d[n_d] = mk_res(KIND_ERR, trow_d, tcol_d, '0, CH_QUOTE);
					else
						res_d[n_d] = mk_res(KIND_DONE, row_d, col_d, '0, 8'h00);
					n_d = n_d + 2'd1;
				end
				res_d[n_d - 2'd1].last = 1'b1;
				mode_d = MODE_IDLE;
				row_d  = '0;
				col_d  = '0;
				trow_d = '0;
				tcol_d = '0;
				tlen_d = '0;
				kw_d   = KW_START;
			end
		end
	end

	assign push           = accept && (n_d != 2'd0);
	assign push_data.cnt  = n_d;
	assign push_data.res  = res_d;

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			row_q  <= '0;
			col_q  <= '0;
			trow_q <= '0;
			tcol_q <= '0;
			tlen_q <= '0;
			kw_q   <= KW_START;
		end else if (accept) begin
			mode_q <= mode_d;
			row_q  <= row_d;
			col_q  <= col_d;
			trow_q <= trow_d;
			tcol_q <= tcol_d;
			tlen_q <= tlen_d;
			kw_q   <= kw_d;
		end
	end

endmodule

@@ design/sxt_queue.sv @@
// ----------------------------------------------------------------------------
// sxt_queue
// Short queue of result bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
module sxt_queue import sxt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output bundle_t head,
	output q_stat_t q_stat
);

	bundle_t              entry_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign q_stat.full  = (count_q == QCNT_BITS'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = entry_q[rd_ptr_q];

	// bundle storage
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_BITS'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_BITS'(1);
		end
	end

endmodule

@@ design/sxt_back.sv @@
// ----------------------------------------------------------------------------
// sxt_back
// Output stage: splits the head bundle into single results and holds each
// in an output register until the consumer takes it.
// ----------------------------------------------------------------------------
module sxt_back import sxt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  bundle_t head,
	input  q_stat_t q_stat,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic       out_valid_q;
	result_t    out_q;
	logic [1:0] sel_q;
	logic       load;
	logic       at_end;

	assign load      = !q_stat.empty && (!out_valid_q || out_ready);
	assign at_end    = (sel_q == head.cnt - 2'd1);
	assign pop       = load && at_end;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// result payload
	always_ff @(posedge clk) begin
		if (load)
			out_q <= head.res[sel_q];
	end

	// output valid and position within bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 2'd0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load)
				sel_q <= at_end ? 2'd0 : sel_q + 2'd1;
		end
	end

endmodule

@@ design/sexpr_tokenizer.sv @@
// ----------------------------------------------------------------------------
// sexpr_tokenizer
// Byte-serial S-expression lexer emitting parenthesis, string, integer,
// identifier, def keyword, error and done tokens with position and length.
// ----------------------------------------------------------------------------
// The block takes one source byte per clock while the queue has room and
// gives at most one token per clock. A byte is scanned in the cycle it is
// accepted; its results (none, or up to three when a byte closes a token,
// makes its own and ends the text) go as one bundle into a four-entry queue,
// and the output register sends them one per cycle while m_tready is high,
// so input keeps flowing until the queue fills. A bundle is registered in
// the queue, then its first token in the output register. Token text is
// not carried: slice it from the source by row, column and length.
// After an error the rest of the text is dropped up to its end marker.
module sexpr_tokenizer import sxt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic        s_tuser,   // char_valid
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // start_row, start_col, token_length, bad_char
	output logic [2:0]  m_tuser,   // token_kind
	output logic        m_tlast    // last_of_run
);

	logic    push;
	bundle_t push_data;
	logic    pop;
	bundle_t head;
	q_stat_t q_stat;
	result_t out_data;

	// scanner
	sxt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.char_code  (s_tdata),
		.char_valid (s_tuser),
		.end_of_text(s_tlast),
		.q_stat     (q_stat),
		.push       (push),
		.push_data  (push_data)
	);

	// bundle queue
	sxt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// output stage
	sxt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_data)
	);

	// output packing
	assign m_tdata = {out_data.bad, out_data.len, out_data.col, out_data.row};
	assign m_tuser = out_data.kind;
	assign m_tlast = out_data.last;

	// scanner never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_stat.full)
		else $error("bundle pushed into full queue");

	// end of run only on done or error
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == KIND_DONE || m_tuser == KIND_ERR))
		else $error("last word is not done or error");

	// done and error carry no length
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_ERR)) |->
		(out_data.len == '0))
		else $error("nonzero length on done or error");

	// offending byte only on error
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_ERR) |-> (out_data.bad == '0))
		else $error("bad byte set on non-error word");

endmodule

@@ tb/sv/sexpr_tokenizer_tb.sv @@
// ----------------------------------------------------------------------------
// sexpr_tokenizer_tb
// Self-checking bench for the byte-serial S-expression lexer. Source bytes
// go in through the slave stream and tokens come out of the master stream.
// Each accepted byte runs through a lexer model in the scoreboard, which
// queues the tokens it should cause. Each token taken from the block is
// checked field by field against the oldest queued token. Stimulus covers
// short hand-picked texts and random well-formed texts broken by stray
// bytes and open strings. Both streams stall at random outside a quiet stretch.
// ----------------------------------------------------------------------------
module sexpr_tokenizer_tb;
	import sxt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// source characters the lexer treats specially
	localparam byte unsigned CH_LPAR  = 8'h28;
	localparam byte unsigned CH_RPAR  = 8'h29;
	localparam byte unsigned CH_QUOTE = 8'h22;
	localparam byte unsigned CH_NL    = 8'h0A;
	localparam byte unsigned CH_SPACE = 8'h20;
	localparam byte unsigned CH_TAB   = 8'h09;
	localparam byte unsigned CH_VT    = 8'h0B;
	localparam byte unsigned CH_FF    = 8'h0C;
	localparam byte unsigned CH_CR    = 8'h0D;
	localparam byte unsigned CH_ZERO  = 8'h30;
	localparam byte unsigned CH_LOW_A = 8'h61;
	localparam byte unsigned CH_UP_A  = 8'h41;

	// random texts to feed, in bytes and end markers
	localparam int RANDOM_WORDS = 320;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	// no idling on either side while set
	bit calm = 1'b0;
	int unsigned fed = 0;

	string kw_words[6] = '{"def", "de", "deff", "d", "Def", "xdef"};

	// character classes
	function automatic bit is_digit(byte unsigned c);
		return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
	endfunction

	function automatic bit is_alpha(byte unsigned c);
		return (c >= CH_LOW_A && c <= CH_LOW_A + 8'd25) ||
			(c >= CH_UP_A && c <= CH_UP_A + 8'd25);
	endfunction

	// blank includes newline, as in the 0x09..0x0d range
	function automatic bit is_blank(byte unsigned c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// ------------------------------------------------------------------------
	// lexer model and token check
	// ------------------------------------------------------------------------
	class token_scoreboard;
		typedef enum logic [2:0] {
			SCAN_IDLE, SCAN_STR, SCAN_INT, SCAN_ID, SCAN_DROP
		} scan_e;

		scan_e       scan;
		pos_t        line_no, col_no, tok_line, tok_colm, tok_size;
		int unsigned kw_pos;
		bit          kw_miss;

		result_t     tokens_due[$];
		int unsigned errors = 0;
		int unsigned seen[8];

		function new();
			clear();
			foreach (seen[k]) seen[k] = 0;
		endfunction

		function void clear();
			scan = SCAN_IDLE;
			line_no = '0;
			col_no = '0;
			tok_line = '0;
			tok_colm = '0;
			tok_size = '0;
			kw_pos = 0;
			kw_miss = 1'b0;
		endfunction

		function pos_t bump(pos_t v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function logic [15:0] clip(pos_t v);
			longint unsigned w;
			w = v;
			return (w > 64'd65535) ? 16'hFFFF : 16'(w);
		endfunction

		function void push(kind_t k, pos_t r, pos_t c, pos_t n, byte unsigned b);
			result_t t;
			t.kind = k;
			t.row = clip(r);
			t.col = clip(c);
			t.len = clip(n);
			t.bad = b;
			t.last = 1'b0;
			tokens_due = {tokens_due, t};
		endfunction

		// track whether the identifier so far spells the keyword
		function void follow_keyword(byte unsigned c);
			string kw;
			kw = "def";
			if (!kw_miss && kw_pos < 3 && c == kw[kw_pos])
				kw_pos++;
			else
				kw_miss = 1'b1;
		endfunction

		function void begin_token(scan_e m);
			scan = m;
			tok_line = line_no;
			tok_colm = col_no;
		endfunction

		// close a pending number or identifier
		function void close_open();
			kind_t k;
			k = KIND_INT;
			if (scan == SCAN_ID)
				k = (!kw_miss && kw_pos == 3) ? KIND_DEF : KIND_ID;
			push(k, tok_line, tok_colm, tok_size, 8'h00);
			scan = SCAN_IDLE;
		endfunction

		// a byte seen with no token open
		function void from_idle(byte unsigned c);
			if (c == CH_LPAR || c == CH_RPAR) begin
				push(c == CH_LPAR ? KIND_LPAR : KIND_RPAR, line_no, col_no, pos_t'(1),
					8'h00);
				col_no = bump(col_no);
			end else if (c == CH_QUOTE) begin
				begin_token(SCAN_STR);
				tok_size = '0;
				col_no = bump(col_no);
			end else if (c == CH_NL) begin
				line_no = bump(line_no);
				col_no = '0;
			end else if (is_blank(c)) begin
				col_no = bump(col_no);
			end else if (is_digit(c)) begin
				begin_token(SCAN_INT);
				tok_size = pos_t'(1);
				col_no = bump(col_no);
			end else if (is_alpha(c)) begin
				begin_token(SCAN_ID);
				tok_size = pos_t'(1);
				kw_pos = 0;
				kw_miss = 1'b0;
				follow_keyword(c);
				col_no = bump(col_no);
			end else begin
				push(KIND_ERR, line_no, col_no, pos_t'(0), c);
				scan = SCAN_DROP;
			end
		endfunction

		// one accepted input word
		function void note_word(byte unsigned c, bit valid, bit eot);
			if (scan == SCAN_DROP) begin
				if (eot)
					clear();
				return;
			end
			if (valid) begin
				if (scan == SCAN_STR) begin
					col_no = bump(col_no);
					if (c == CH_QUOTE) begin
						push(KIND_STR, tok_line, tok_colm, tok_size, 8'h00);
						scan = SCAN_IDLE;
					end else begin
						tok_size = bump(tok_size);
					end
				end else if (scan == SCAN_INT && is_digit(c)) begin
					tok_size = bump(tok_size);
					col_no = bump(col_no);
				end else if (scan == SCAN_ID && is_alpha(c)) begin
					tok_size = bump(tok_size);
					follow_keyword(c);
					col_no = bump(col_no);
				end else begin
					if (scan == SCAN_INT || scan == SCAN_ID)
						close_open();
					from_idle(c);
				end
			end
			if (eot) begin
				if (scan != SCAN_DROP) begin
					if (scan == SCAN_INT || scan == SCAN_ID)
						close_open();
					if (scan == SCAN_STR)
						push(KIND_ERR, tok_line, tok_colm, pos_t'(0), CH_QUOTE);
					else
						push(KIND_DONE, line_no, col_no, pos_t'(0), 8'h00);
				end
				tokens_due[tokens_due.size() - 1].last = 1'b1;
				clear();
			end
		endfunction

		function void compare(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// one token taken from the block
		function void check_token(logic [2:0] kind, logic [55:0] data, logic last);
			result_t want;
			if (tokens_due.size() == 0) begin
				$error("unexpected token: kind %0d row %0d col %0d",
					kind, data[15:0], data[31:16]);
				errors++;
				return;
			end
			want = tokens_due.pop_front();
			seen[want.kind]++;
			compare("token_kind", 16'(want.kind), 16'(kind));
			compare("start_row", want.row, data[15:0]);
			compare("start_col", want.col, data[31:16]);
			compare("token_length", want.len, data[47:32]);
			compare("bad_char", 16'(want.bad), 16'(data[55:48]));
			compare("last_of_run", 16'(want.last), 16'(last));
		endfunction
	endclass

	token_scoreboard sb = new();

	sexpr_tokenizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// random stalls on the token side
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 14);
	end

	// watch both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_word(s_tdata, s_tuser, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_token(m_tuser, m_tdata, m_tlast);
		end
	end

	// ------------------------------------------------------------------------
	// byte side drivers
	// ------------------------------------------------------------------------
	task automatic send_word(byte unsigned c, bit valid, bit eot, bit tally);
		while (!calm && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= valid;
		s_tlast <= eot;
		do @(posedge clk); while (!s_tready);
		if (tally)
			fed++;
	endtask

	// a literal text, the end marker riding on its last byte if asked
	task automatic send_text(string s, bit eot);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b1, eot && i == s.len() - 1, 1'b1);
	endtask

	function automatic byte unsigned blank_byte();
		case ($urandom_range(0, 4))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			3: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic byte unsigned letter_byte();
		int unsigned k;
		k = $urandom_range(0, 51);
		return (k < 26) ? CH_LOW_A + 8'(k) : CH_UP_A + 8'(k - 26);
	endfunction

	function automatic byte unsigned digit_byte();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// anything but the closing quote
	function automatic byte unsigned string_byte();
		byte unsigned c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
		return c;
	endfunction

	// a byte that starts no token
	function automatic byte unsigned stray_byte();
		byte unsigned c;
		do c = 8'($urandom_range(0, 255));
		while (c == CH_LPAR || c == CH_RPAR || c == CH_QUOTE || is_blank(c) ||
			is_digit(c) || is_alpha(c));
		return c;
	endfunction

	// end of text, bare or on a final byte of any class
	task automatic send_end();
		byte unsigned c;
		if ($urandom_range(0, 9) < 5) begin
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
		end else begin
			case ($urandom_range(0, 7))
				0: c = CH_LPAR;
				1: c = CH_RPAR;
				2: c = digit_byte();
				3: c = letter_byte();
				4: c = blank_byte();
				5: c = CH_NL;
				6: c = CH_QUOTE;
				default: c = stray_byte();
			endcase
			send_word(c, 1'b1, 1'b1, 1'b1);
		end
	endtask

	// one random text: mostly well-formed tokens, some noise and breakage
	task automatic send_random_text();
		int pieces;
		int pick;
		int n;
		pieces = $urandom_range(1, 8);
		for (int p = 0; p < pieces; p++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				send_word(CH_LPAR, 1'b1, 1'b0, 1'b1);
			end else if (pick < 24) begin
				send_word(CH_RPAR, 1'b1, 1'b0, 1'b1);
			end else if (pick < 38) begin
				send_word(CH_QUOTE, 1'b1, 1'b0, 1'b1);
				n = $urandom_range(0, 6);
				repeat (n) send_word(string_byte(), 1'b1, 1'b0, 1'b1);
				send_word(CH_QUOTE, 1'b1, 1'b0, 1'b1);
			end else if (pick < 52) begin
				n = $urandom_range(1, 5);
				repeat (n) send_word(digit_byte(), 1'b1, 1'b0, 1'b1);
				if ($urandom_range(0, 9) < 6)
					send_word(CH_SPACE, 1'b1, 1'b0, 1'b1);
			end else if (pick < 72) begin
				if ($urandom_range(0, 9) < 4) begin
					send_text(kw_words[$urandom_range(0, 5)], 1'b0);
				end else begin
					n = $urandom_range(1, 6);
					repeat (n) send_word(letter_byte(), 1'b1, 1'b0, 1'b1);
				end
				if ($urandom_range(0, 9) < 6)
					send_word(blank_byte(), 1'b1, 1'b0, 1'b1);
			end else if (pick < 89) begin
				n = $urandom_range(1, 3);
				repeat (n)
					send_word(($urandom_range(0, 3) == 0) ? CH_NL : blank_byte(),
						1'b1, 1'b0, 1'b1);
			end else if (pick < 93) begin
				// ignored word without a byte
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
			end else if (pick < 96) begin
				// error, then bytes that are dropped
				send_word(stray_byte(), 1'b1, 1'b0, 1'b1);
				n = $urandom_range(0, 2);
				repeat (n) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
				break;
			end else begin
				// string left open at the end of text
				send_word(CH_QUOTE, 1'b1, 1'b0, 1'b1);
				n = $urandom_range(0, 4);
				repeat (n) send_word(string_byte(), 1'b1, 1'b0, 1'b1);
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
				return;
			end
		end
		send_end();
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		int waited;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// parens, keyword, number and done on a byte with the end marker
		send_text("(def\t42)", 1'b1);
		// string spanning a newline, then a bare end marker
		send_text("\"a\nb\"", 1'b0);
		send_word(8'hFF, 1'b0, 1'b1, 1'b1);
		// identifier closed by the end of text
		send_text("xyz", 1'b1);
		// one byte closing a number, giving a paren and ending the text
		send_text("7(", 1'b1);
		// open string at the end of text
		send_text("\"q", 1'b1);
		// non-ASCII byte, a dropped byte, then the end marker
		send_word(8'hFF, 1'b1, 1'b0, 1'b1);
		send_word(CH_LPAR, 1'b1, 1'b0, 1'b1);
		send_word(8'h00, 1'b0, 1'b1, 1'b1);
		// error on the byte that carries the end marker
		send_word(8'h00, 1'b1, 1'b1, 1'b1);
		// ignored word, then a blank ending the text
		send_word(8'hA5, 1'b0, 1'b0, 1'b0);
		send_word(CH_SPACE, 1'b1, 1'b1, 1'b1);

		// random texts, with a quiet stretch in the middle
		fed = 0;
		while (fed < RANDOM_WORDS) begin
			calm = (fed >= 140 && fed < 240);
			send_random_text();
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// drain
		waited = 0;
		while (sb.tokens_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (sb.tokens_due.size() != 0) begin
			$error("%0d expected tokens never arrived", sb.tokens_due.size());
			sb.errors++;
		end

		$display("fed hand-picked and random texts; checked %0d tokens",
			sb.seen.sum());
		$display("  lpar %0d rpar %0d str %0d int %0d id %0d def %0d err %0d done %0d",
			sb.seen[KIND_LPAR], sb.seen[KIND_RPAR], sb.seen[KIND_STR],
			sb.seen[KIND_INT], sb.seen[KIND_ID], sb.seen[KIND_DEF],
			sb.seen[KIND_ERR], sb.seen[KIND_DONE]);
		if (sb.errors == 0)
			$display("[sexpr_tokenizer] OK");
		else
			$display("[sexpr_tokenizer] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("[sexpr_tokenizer] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
design/sxt_pkg.sv
design/sxt_front.sv
design/sxt_queue.sv
design/sxt_back.sv
design/sexpr_tokenizer.sv
tb/sv/sexpr_tokenizer_tb.sv
